// ----- rtl/lps_pkg.sv -----
// Shared types and defaults for the Legendre polynomial sequence generator.
package lps_pkg;

  localparam int unsigned MaxDegreeDef = 63;
  localparam int unsigned FracBitsDef  = 30;
  localparam int unsigned XW           = 32;
  localparam int unsigned DEG_W        = 6;
  // quotient bits retired per divider cycle
  localparam int unsigned DigitBits    = 8;

  typedef struct packed {
    logic signed [XW-1:0] x_value;
    logic [DEG_W-1:0]     degree;
  } in_item_t;

  typedef struct packed {
    logic signed [XW-1:0] poly_value;
    logic [DEG_W-1:0]     order_index;
    logic                 last;
  } out_item_t;

endpackage

// ----- rtl/legendre_polynomial_sequence.sv -----
// Legendre polynomial sequence generator: P_0(x)..P_L(x) by the three-term recurrence.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_ready_o | in_item_t  {x_value, degree}
//   out     | output    | out_valid_o/out_ready_i | out_item_t {poly_value, order_index, last}
//
// One item of degree L gives L+1 transfers. P_0 and P_1 are loaded straight into the output
// register; each higher degree passes through three multiply/accumulate steps, one rounding
// step, the divider by k (DigitBits quotient bits a cycle), one finish step and the output
// register, where it waits out any output stall; a saturating term skips the divider.
// in_ready_o is high only in idle; the output register holds each result until taken.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle with no result pending.
module legendre_polynomial_sequence
  import lps_pkg::*;
#(
  parameter int unsigned MAX_DEGREE = MaxDegreeDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned VAL_W     = FRAC_BITS + 2;
  localparam int unsigned PROD_W    = 2 * VAL_W;
  localparam int unsigned NUM_W     = 2 * FRAC_BITS + 9;
  localparam int unsigned T_W       = NUM_W - FRAC_BITS;
  localparam int unsigned DIVD_W    = FRAC_BITS + DEG_W;
  localparam int unsigned DIV_STEPS = (DIVD_W + DigitBits - 1) / DigitBits;
  localparam int unsigned DQ_W      = DIV_STEPS * DigitBits;
  localparam int unsigned CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int unsigned REM_W     = DEG_W + 1;

  localparam logic signed [VAL_W-1:0] OneVal  = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [XW-1:0]    XOne    = XW'(OneVal);
  localparam logic [DQ_W-1:0]         OneMag  = DQ_W'(OneVal);
  localparam logic [DEG_W-1:0]        DegMax  = DEG_W'(MAX_DEGREE);
  localparam logic [CNT_W-1:0]        CntLast = CNT_W'(DIV_STEPS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EMIT  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_SUB   = 3'd4;
  localparam logic [2:0] S_RND   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  // control state
  logic [2:0]       state_q, state_d;
  logic [DEG_W-1:0] k_q, k_d;
  logic [DEG_W-1:0] deg_q, deg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // datapath
  logic signed [VAL_W-1:0]  x_q, x_d;
  logic signed [VAL_W-1:0]  older_q, older_d;
  logic signed [VAL_W-1:0]  newer_q, newer_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [NUM_W-1:0]  num_q, num_d;
  logic                     neg_q, neg_d;
  logic                     sat_q, sat_d;
  logic [DQ_W-1:0]          dq_q, dq_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  out_item_t                out_q, out_d;

  // combinational helpers
  logic signed [VAL_W-1:0]  x_clamp;
  logic [DEG_W-1:0]         deg_clamp;
  logic [DEG_W:0]           k_odd;
  logic [DEG_W-1:0]         k_less;
  logic [NUM_W-1:0]         num_mag;
  logic [NUM_W-1:0]         num_rnd;
  logic [T_W-1:0]           t_val;
  logic [T_W-1:0]           sat_bound;
  logic [REM_W-1:0]         div_rem;
  logic [DQ_W-1:0]          div_dq;
  logic signed [VAL_W-1:0]  fin_mag;
  logic signed [VAL_W-1:0]  fin_val;

  always_comb begin
    if (in_item_i.x_value > XOne) begin
      x_clamp = OneVal;
    end else if (in_item_i.x_value < -XOne) begin
      x_clamp = -OneVal;
    end else begin
      x_clamp = in_item_i.x_value[VAL_W-1:0];
    end
    deg_clamp = (in_item_i.degree > DegMax) ? DegMax : in_item_i.degree;
  end

  assign k_odd  = {k_q, 1'b0} - (DEG_W+1)'(1);
  assign k_less = k_q - DEG_W'(1);

  // round half away from zero: floor((|N| + den/2) / den), den = k * 2^F,
  // taken as a shift by F followed by an integer divide by k
  assign num_mag   = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign num_rnd   = num_mag + (NUM_W'(k_q) << (FRAC_BITS - 1));
  assign t_val     = T_W'(num_rnd >> FRAC_BITS);
  assign sat_bound = (T_W'(k_q) << FRAC_BITS) + T_W'(k_q);

  // restoring divide by k, DigitBits quotient bits a cycle
  always_comb begin
    div_rem = rem_q;
    div_dq  = dq_q;
    for (int i = 0; i < DigitBits; i++) begin
      div_rem = {div_rem[REM_W-2:0], div_dq[DQ_W-1]};
      div_dq  = {div_dq[DQ_W-2:0], 1'b0};
      if (div_rem >= {1'b0, k_q}) begin
        div_rem   = div_rem - {1'b0, k_q};
        div_dq[0] = 1'b1;
      end
    end
  end

  assign fin_mag = (sat_q || (dq_q > OneMag)) ? OneVal : dq_q[VAL_W-1:0];
  assign fin_val = neg_q ? -fin_mag : fin_mag;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    deg_d       = deg_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    x_d         = x_q;
    older_d     = older_q;
    newer_d     = newer_q;
    prod_d      = prod_q;
    num_d       = num_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d         = x_clamp;
          deg_d       = deg_clamp;
          k_d         = '0;
          older_d     = '0;
          newer_d     = OneVal;
          out_d       = '{poly_value: XOne, order_index: '0, last: (deg_clamp == '0)};
          out_valid_d = 1'b1;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (k_q == deg_q) begin
            state_d = S_IDLE;
          end else if (k_q == '0) begin
            // P_1 is the point itself, no rounding
            k_d         = DEG_W'(1);
            older_d     = OneVal;
            newer_d     = x_q;
            out_d       = '{poly_value: XW'(x_q), order_index: DEG_W'(1),
                            last: (deg_q == DEG_W'(1))};
            out_valid_d = 1'b1;
          end else begin
            k_d     = k_q + DEG_W'(1);
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(x_q) * PROD_W'(newer_q);
        state_d = S_SCALE;
      end
      S_SCALE: begin
        num_d   = NUM_W'(prod_q) * NUM_W'($signed({1'b0, k_odd}));
        state_d = S_SUB;
      end
      S_SUB: begin
        num_d   = num_q - ((NUM_W'(older_q) * NUM_W'($signed({1'b0, k_less})))
                           <<< FRAC_BITS);
        state_d = S_RND;
      end
      S_RND: begin
        neg_d   = num_q[NUM_W-1];
        sat_d   = (t_val >= sat_bound);
        dq_d    = DQ_W'(t_val[DIVD_W-1:0]);
        rem_d   = '0;
        cnt_d   = '0;
        // a quotient above 1.0 needs no divide
        state_d = (t_val >= sat_bound) ? S_FIN : S_DIV;
      end
      S_DIV: begin
        dq_d  = div_dq;
        rem_d = div_rem;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CntLast) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        older_d     = newer_q;
        newer_d     = fin_val;
        out_d       = '{poly_value: XW'(fin_val), order_index: k_q, last: (k_q == deg_q)};
        out_valid_d = 1'b1;
        state_d     = S_EMIT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      deg_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      deg_q       <= deg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    older_q <= older_d;
    newer_q <= newer_d;
    prod_q  <= prod_d;
    num_q   <= num_d;
    neg_q   <= neg_d;
    sat_q   <= sat_d;
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a result is pending");

  a_first_is_p0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o && (out_item_o.order_index == '0))
    else $error("first result after a transfer in is not degree zero");

  a_value_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.poly_value <= XOne) && (out_item_o.poly_value >= -XOne))
    else $error("result value beyond +-1.0");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.last |=> in_ready_o)
    else $error("block not idle after the last transfer out");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the Legendre polynomial sequence generator.
`timescale 1ns / 100ps

module testbench
  import lps_pkg::*;
();

  localparam longint OneQ = longint'(1) << FracBitsDef;
  localparam logic [XW-1:0] PosOne = 32'h4000_0000;
  localparam logic [XW-1:0] NegOne = 32'hC000_0000;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned TailCycles = 60;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  out_item_t   expected_terms[$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned take_stall_pct = 0;

  legendre_polynomial_sequence dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // floor division by a positive divisor; remainder lands in [0, d)
  function automatic longint floor_quot(input longint a, input longint d, output longint rem);
    longint q;
    longint r;
    q = a / d;
    r = a % d;
    if (r < 0) begin
      q -= 1;
      r += d;
    end
    rem = r;
    return q;
  endfunction

  // P_k from P_{k-1} and P_{k-2}: exact numerator, round half away from zero, saturate
  function automatic longint bonnet_term(longint k, longint x, longint p1, longint p0);
    longint den, q, r, a, aq, ar, big, f, rr;
    den = k * OneQ;
    q = floor_quot(x * p1, OneQ, r);
    a = (2 * k - 1) * q - (k - 1) * p0;
    aq = floor_quot(a, k, ar);
    big = ar * OneQ + (2 * k - 1) * r;
    f = aq + big / den;
    rr = big % den;
    if (f >= 0) begin
      if (2 * rr >= den) f += 1;
    end else begin
      if (2 * rr > den) f += 1;
    end
    if (f > OneQ) f = OneQ;
    if (f < -OneQ) f = -OneQ;
    return f;
  endfunction

  function automatic out_item_t make_term(longint v, int unsigned k, int unsigned deg);
    out_item_t t;
    t.poly_value  = v[XW-1:0];
    t.order_index = DEG_W'(k);
    t.last        = (k == deg);
    return t;
  endfunction

  task automatic predict_terms(input in_item_t item);
    longint      x, p_old, p_new, p_next;
    int unsigned deg;
    x = longint'(item.x_value);
    if (x > OneQ) x = OneQ;
    if (x < -OneQ) x = -OneQ;
    deg = 32'(item.degree);
    if (deg > MaxDegreeDef) deg = MaxDegreeDef;
    expected_terms.push_back(make_term(OneQ, 0, deg));
    if (deg >= 1) expected_terms.push_back(make_term(x, 1, deg));
    p_old = OneQ;
    p_new = x;
    for (int unsigned k = 2; k <= deg; k++) begin
      p_next = bonnet_term(longint'(k), x, p_new, p_old);
      p_old  = p_new;
      p_new  = p_next;
      expected_terms.push_back(make_term(p_next, k, deg));
    end
  endtask

  // hold valid and payload until the transfer, then record the expected terms
  task automatic send_point(input logic [XW-1:0] x, input logic [DEG_W-1:0] deg);
    in_item_t item;
    item.x_value = x;
    item.degree  = deg;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_terms(item);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [XW-1:0] random_point();
    int unsigned sel;
    logic [XW-1:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      v = XW'(longint'($urandom_range(0, 32'h8000_0000)) - OneQ);
    end else if (sel < 70) begin
      v = $urandom;
    end else if (sel < 80) begin
      v = PosOne - XW'($urandom_range(0, 64));
      if ($urandom_range(0, 1)) v = -v;
    end else if (sel < 90) begin
      v = XW'($urandom_range(0, 4096));
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = PosOne + XW'($urandom_range(0, 1000));
      if ($urandom_range(0, 1)) v = -v;
    end
    return v;
  endfunction

  function automatic logic [DEG_W-1:0] random_degree();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return DEG_W'($urandom_range(0, 10));
    if (sel < 90) return DEG_W'($urandom_range(11, 40));
    return DEG_W'($urandom_range(41, 63));
  endfunction

  task automatic test_point_extremes();
    send_point(PosOne, 6'd63);
    send_point(NegOne, 6'd63);
    send_point(32'h0000_0000, 6'd63);
    send_point(32'h7FFF_FFFF, 6'd5);
    send_point(32'h8000_0000, 6'd5);
    send_point(32'h4000_0001, 6'd3);
    send_point(32'hBFFF_FFFF, 6'd3);
    send_point(32'h0000_0001, 6'd2);
    send_point(32'hFFFF_FFFF, 6'd2);
  endtask

  task automatic test_short_degrees();
    send_point(32'h1234_5678, 6'd0);
    send_point(32'hE000_0000, 6'd0);
    send_point(32'h2000_0000, 6'd1);
    send_point(32'hD000_0000, 6'd1);
    send_point(32'h7FFF_FFFF, 6'd1);
    send_point(32'h2AAA_AAAB, 6'd2);
    send_point(32'h0000_0000, 6'd2);
  endtask

  // near the ends of the interval rounding can push a term past unity
  task automatic test_saturation_near_unity();
    send_point(32'h3FFF_FFFF, 6'd63);
    send_point(32'hC000_0001, 6'd63);
    send_point(32'h3FFF_FFFE, 6'd40);
    send_point(32'hC000_0064, 6'd63);
  endtask

  task automatic test_drain_pause();
    send_point(32'h1234_5678, 6'd30);
    drop_valid();
    while (expected_terms.size() != 0) @(posedge clk_i);
    send_point(32'hDEAD_BEEF, 6'd4);
    send_point(32'h3000_0000, 6'd12);
  endtask

  task automatic test_random_points(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_point(random_point(), random_degree());
  endtask

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= take_stall_pct);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (expected_terms.size() == 0) begin
        $error("unexpected result: order_index %0d poly_value %0d",
               out_item_o.order_index, $signed(out_item_o.poly_value));
        fail_count++;
      end else begin
        want = expected_terms.pop_front();
        if (out_item_o.poly_value !== want.poly_value) begin
          $error("poly_value: expected %0d, actual %0d (degree %0d)",
                 $signed(want.poly_value), $signed(out_item_o.poly_value), want.order_index);
          fail_count++;
        end
        if (out_item_o.order_index !== want.order_index) begin
          $error("order_index: expected %0d, actual %0d",
                 want.order_index, out_item_o.order_index);
          fail_count++;
        end
        if (out_item_o.last !== want.last) begin
          $error("last: expected %0d, actual %0d (degree %0d)",
                 want.last, out_item_o.last, want.order_index);
          fail_count++;
        end
      end
    end
  end

  // end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = 28;
    take_stall_pct = 59;
    test_point_extremes();
    test_short_degrees();
    test_saturation_near_unity();
    test_drain_pause();
    test_random_points(54);

    send_gap_pct   = 59;
    take_stall_pct = 28;
    test_random_points(54);

    send_gap_pct   = 0;
    take_stall_pct = 0;
    test_random_points(54);
    drop_valid();

    while (expected_terms.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
